@@ sv/template_tag_splitter_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the template tag splitter
// Concurrent checks sampled on clk and held off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef TEMPLATE_TAG_SPLITTER_ASSERT_SVH
`define TEMPLATE_TAG_SPLITTER_ASSERT_SVH
`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("template_tag_splitter check failed");
// Consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("template_tag_splitter check failed");
`else
`define TTS_ASSERT_SAME(lbl, ante, cons)
`define TTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/tts_pkg.sv @@
// ---------------------------------------------------------------------------
// tts_pkg
// Types and constants shared by the template tag splitter modules.
// ---------------------------------------------------------------------------
package tts_pkg;

	// Region codes.
	localparam logic [1:0] REGION_PLAIN = 2'd0;
	localparam logic [1:0] REGION_BODY  = 2'd1;
	localparam logic [1:0] REGION_HEAD  = 2'd2;

	// Delimiter and quote characters.
	localparam logic [7:0] CHAR_LT     = 8'h3C;
	localparam logic [7:0] CHAR_GT     = 8'h3E;
	localparam logic [7:0] CHAR_QMARK  = 8'h3F;
	localparam logic [7:0] CHAR_PCT    = 8'h25;
	localparam logic [7:0] CHAR_DQUOTE = 8'h22;
	localparam logic [7:0] CHAR_SQUOTE = 8'h27;

	// Most results one input byte can cause.
	localparam int MAX_RESULTS = 3;

	typedef logic [1:0] res_count_t;

	typedef struct packed {
		logic       quote_open;
		logic       segment_end;
		logic       has_byte;
		logic [1:0] region_kind;
		logic [7:0] text_byte;
		logic       last_of_item;
	} tts_result_t;

	// Status of the output buffer seen by the input side.
	typedef struct packed {
		logic can_load;
	} tts_buf_status_t;

endpackage

@@ sv/tts_scan.sv @@
// ---------------------------------------------------------------------------
// tts_scan
// Scanner state and the combinational step that turns one byte into results.
// ---------------------------------------------------------------------------
module tts_scan
	import tts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_in,
	input  logic        eof_in,
	output tts_result_t res [MAX_RESULTS],
	output res_count_t  res_count
);

	logic [1:0] region_q;
	logic       quote_q;
	logic       held_valid_q;
	logic [7:0] held_byte_q;
	logic       nonempty_q;

	logic        closes;
	logic [1:0]  close_region;
	logic        start;
	logic        is_quote;
	logic        consumed;
	logic [1:0]  region_nx;
	logic        quote_nx;
	logic        held_valid_nx;
	logic        nonempty_a;
	logic        nonempty_nx;
	logic        slot_v [MAX_RESULTS];
	tts_result_t slot   [MAX_RESULTS];
	res_count_t  cnt;

	always_comb begin
		closes       = 1'b0;
		close_region = REGION_PLAIN;
		if (region_q == REGION_PLAIN) begin
			if (held_byte_q == CHAR_LT && (byte_in == CHAR_QMARK || byte_in == CHAR_PCT)) begin
				closes       = 1'b1;
				close_region = (byte_in == CHAR_QMARK) ? REGION_BODY : REGION_HEAD;
			end
		end else if ((held_byte_q == CHAR_QMARK || held_byte_q == CHAR_PCT)
				&& byte_in == CHAR_GT) begin
			closes = 1'b1;
		end

		if (quote_q)
			start = 1'b0;
		else if (region_q == REGION_PLAIN)
			start = (byte_in == CHAR_LT);
		else
			start = (byte_in == CHAR_QMARK || byte_in == CHAR_PCT);

		is_quote      = (byte_in == CHAR_DQUOTE || byte_in == CHAR_SQUOTE);
		consumed      = held_valid_q && closes;
		region_nx     = consumed ? close_region : region_q;
		held_valid_nx = !consumed && start;
		quote_nx      = quote_q ^ (!consumed && !start && is_quote);
		nonempty_a    = consumed ? 1'b0 : (held_valid_q ? 1'b1 : nonempty_q);

		// First slot: the held byte, either a delimiter close or content.
		slot_v[0]              = held_valid_q;
		slot[0]                = '0;
		slot[0].region_kind    = region_q;
		slot[0].segment_end    = consumed;
		slot[0].has_byte       = !consumed;
		slot[0].text_byte      = consumed ? 8'h00 : held_byte_q;

		// Second slot: the new byte, as content or flushed at end of file.
		slot_v[1]              = !consumed && (!start || eof_in);
		slot[1]                = '0;
		slot[1].region_kind    = region_q;
		slot[1].has_byte       = 1'b1;
		slot[1].text_byte      = byte_in;

		nonempty_nx = slot_v[1] ? 1'b1 : nonempty_a;

		// Third slot: tail close at end of file.
		slot_v[2]              = eof_in && nonempty_nx;
		slot[2]                = '0;
		slot[2].region_kind    = region_nx;
		slot[2].segment_end    = 1'b1;
		slot[2].quote_open     = quote_nx;
	end

	// Pack the valid slots to the front and mark the final one.
	always_comb begin
		cnt = '0;
		for (int i = 0; i < MAX_RESULTS; i++)
			res[i] = '0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (slot_v[i]) begin
				res[cnt] = slot[i];
				cnt      = cnt + 2'd1;
			end
		end
		for (int i = 0; i < MAX_RESULTS; i++)
			res[i].last_of_item = (cnt != '0) && (res_count_t'(i) == cnt - 2'd1);
		res_count = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q     <= REGION_PLAIN;
			quote_q      <= 1'b0;
			held_valid_q <= 1'b0;
			held_byte_q  <= '0;
			nonempty_q   <= 1'b0;
		end else if (step) begin
			if (eof_in) begin
				region_q     <= REGION_PLAIN;
				quote_q      <= 1'b0;
				held_valid_q <= 1'b0;
				held_byte_q  <= '0;
				nonempty_q   <= 1'b0;
			end else begin
				region_q     <= region_nx;
				quote_q      <= quote_nx;
				held_valid_q <= held_valid_nx;
				held_byte_q  <= byte_in;
				nonempty_q   <= nonempty_nx;
			end
		end
	end

endmodule

@@ sv/tts_out_buf.sv @@
// ---------------------------------------------------------------------------
// tts_out_buf
// Result register bank that presents up to three results one beat at a time.
// ---------------------------------------------------------------------------
module tts_out_buf
	import tts_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  tts_result_t     load_res [MAX_RESULTS],
	input  res_count_t      load_count,
	input  logic            take,
	output tts_result_t     head,
	output logic            head_valid,
	output tts_buf_status_t status
);

	tts_result_t res_q [MAX_RESULTS];
	res_count_t  remain_q;

	assign head_valid      = (remain_q != '0);
	assign head            = res_q[0];
	// A new set may land when the bank is empty or its last pending beat leaves in this cycle.
	assign status.can_load = (remain_q == '0) || (remain_q == 2'd1 && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			remain_q <= '0;
		else if (load)
			remain_q <= load_count;
		else if (take)
			remain_q <= remain_q - 2'd1;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RESULTS; i++)
				res_q[i] <= load_res[i];
		end else if (take) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++)
				res_q[i] <= res_q[i + 1];
		end
	end

endmodule

@@ sv/template_tag_splitter.sv @@
// ---------------------------------------------------------------------------
// template_tag_splitter
// Splits a template byte stream into plain, body-code and head-code segments.
// ---------------------------------------------------------------------------
//
//   channel   direction  beat contents
//   s_axis    in         tdata[7:0] template byte, tlast end of file
//   m_axis    out        tdata[7:0] content byte, tuser region/flags,
//                        tlast last result caused by one input byte
//
// An input byte is captured into an input register, stepped through the
// scanner and its zero to three results land in a result bank. A byte
// that gives one result sustains one beat per cycle while m_axis is ready;
// each extra result (a held byte flushed with its successor, or a tail
// close at end of file) stalls the input while the bank drains.
// An input beat passes the input register and then the result bank.
// Reset puts the scanner in plain text with nothing held and the bank empty.
// Back-pressure on m_axis stalls the bank, then the input register, then
// s_axis_tready falls.
// ---------------------------------------------------------------------------
`include "template_tag_splitter_assert.svh"

module template_tag_splitter
	import tts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] text_byte_in
	input  logic       s_axis_tlast,   // end_of_file
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] text_byte_out
	output logic [4:0] m_axis_tuser,   // [1:0] region_kind, [2] has_byte,
	                                   // [3] segment_end, [4] quote_open
	output logic       m_axis_tlast    // last_of_item
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	logic            step;
	logic            in_beat;
	logic            out_beat;
	tts_result_t     scan_res [MAX_RESULTS];
	res_count_t      scan_count;
	tts_result_t     head;
	logic            head_valid;
	tts_buf_status_t buf_status;

	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_beat      = m_axis_tvalid && m_axis_tready;
	// The buffered byte is scanned only when the bank can hold its results.
	assign step          = valid_s1 && buf_status.can_load;
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			byte_s1 <= s_axis_tdata;
			eof_s1  <= s_axis_tlast;
		end
	end

	tts_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (byte_s1),
		.eof_in    (eof_s1),
		.res       (scan_res),
		.res_count (scan_count)
	);

	tts_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (step),
		.load_res   (scan_res),
		.load_count (scan_count),
		.take       (out_beat),
		.head       (head),
		.head_valid (head_valid),
		.status     (buf_status)
	);

	assign m_axis_tvalid = head_valid;
	assign m_axis_tdata  = head.text_byte;
	assign m_axis_tuser  = {head.quote_open, head.segment_end, head.has_byte, head.region_kind};
	assign m_axis_tlast  = head.last_of_item;

	// A segment close never carries a content byte.
	`TTS_ASSERT_SAME(a_end_no_byte, m_axis_tvalid && m_axis_tuser[3], !m_axis_tuser[2])
	// An open quote is only reported on a segment close.
	`TTS_ASSERT_SAME(a_quote_on_end, m_axis_tvalid && m_axis_tuser[4], m_axis_tuser[3])
	// Only the three defined region codes are produced.
	`TTS_ASSERT_SAME(a_region_legal, m_axis_tvalid, m_axis_tuser[1:0] == REGION_PLAIN || m_axis_tuser[1:0] == REGION_BODY || m_axis_tuser[1:0] == REGION_HEAD)
	// A byte waiting on a full bank stays in the input register unchanged.
	`TTS_ASSERT_NEXT(a_s1_hold, valid_s1 && !buf_status.can_load, valid_s1 && $stable(byte_s1) && $stable(eof_s1))

endmodule
